[sv/modular_exponentiation_macros.svh]
// Assertion macros for the modular exponentiation block.
// Used by the top level; needs a clk and an rst_n in the scope of each use.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MEXP_ASSERT_SAME(lbl, ante, cons, msg)
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/mexp_pkg.sv]
// Shared widths, constants and controller/datapath interface types
// for the modular exponentiation block. No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int MOD_WIDTH     = 31;
  localparam int IN_WIDTH      = 32;
  localparam int E_WIDE        = 64;
  localparam int EXP_WIDTH_DEF = 32;

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

  typedef logic [MOD_WIDTH-1:0] mod_t;
  typedef logic [IN_WIDTH-1:0]  word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new word and start the base reduction
    logic take_base;  // store the reduced base
    logic mul_start;  // start the square and the multiply for one bit
    logic mul_take;   // store square/product and shift the exponent
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;   // no exponent bits left
    logic unit_done;  // modular multipliers finished
  } sts_t;

endpackage

`default_nettype wire

[sv/mexp_modmul.sv]
// Iterative interleaved modular multiplier: one bit of b per cycle.
// Depends on mexp_pkg.
`default_nettype none

module mexp_modmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mexp_pkg::mod_t  a_in,
  input  mexp_pkg::word_t b_in,
  input  mexp_pkg::mod_t  m_in,
  output mexp_pkg::mod_t  prod,
  output logic           done
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(IN_WIDTH);

  mod_t             a_r, m_r, r_r, r_nxt;
  word_t            b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [MOD_WIDTH+1:0] t;
  logic [MOD_WIDTH+2:0] d1, d2;

  // r = 2r + bit*a stays below 3m, so at most two subtractions of m.
  always_comb begin
    t  = {1'b0, r_r, 1'b0} + (b_r[IN_WIDTH-1] ? {2'b0, a_r} : '0);
    d1 = {1'b0, t} - {3'b0, m_r};
    d2 = {1'b0, t} - {2'b0, m_r, 1'b0};
    if (!d2[MOD_WIDTH+2]) begin
      r_nxt = d2[MOD_WIDTH-1:0];
    end else if (!d1[MOD_WIDTH+2]) begin
      r_nxt = d1[MOD_WIDTH-1:0];
    end else begin
      r_nxt = t[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(IN_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      m_r <= m_in;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[IN_WIDTH-2:0], 1'b0};
    end
  end

  assign prod = r_r;
  assign done = done_r;

endmodule

`default_nettype wire

[sv/mexp_datapath.sv]
// Datapath: modulus register, base/result/exponent registers and two
// modular multipliers. Depends on mexp_pkg and mexp_modmul.
`default_nettype none

module mexp_datapath #(
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mexp_pkg::cmd_t  cmd,
  output mexp_pkg::sts_t  sts,
  input  logic           in_mode,
  input  mexp_pkg::word_t in_base_value,
  input  mexp_pkg::word_t in_exponent,
  input  logic           cfg_we,
  input  mexp_pkg::mod_t  cfg_wdata,
  output mexp_pkg::mod_t  out_power_result
);
  import mexp_pkg::*;

  mod_t                 modulus_r, m_eff;
  mod_t                 base_r, res_r;
  logic [EXP_WIDTH-1:0] e_r;
  logic [E_WIDE-1:0]    e_wide;
  mod_t                 u0_a, u0_p, u1_p;
  word_t                u0_b;
  logic                 u0_done, u1_done;

  // A zero modulus behaves as a modulus of one.
  assign m_eff = (modulus_r == '0) ? MOD_WIDTH'(1) : modulus_r;

  always_comb begin
    if (!in_mode) begin
      e_wide = {{(E_WIDE-IN_WIDTH){1'b0}}, in_exponent};
    end else if (modulus_r < MOD_WIDTH'(2)) begin
      e_wide = '0;
    end else begin
      e_wide = {{(E_WIDE-MOD_WIDTH){1'b0}}, m_eff - MOD_WIDTH'(2)};
    end
  end

  // Unit 0 reduces the base on load and squares it afterwards.
  assign u0_a = cmd.load ? MOD_WIDTH'(1) : base_r;
  assign u0_b = cmd.load ? in_base_value : {1'b0, base_r};

  mexp_modmul u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load | cmd.mul_start),
    .a_in  (u0_a),
    .b_in  (u0_b),
    .m_in  (m_eff),
    .prod  (u0_p),
    .done  (u0_done)
  );

  // Unit 1 also runs during the base reduction so that both units always
  // finish together; its product from that pass is never stored.
  mexp_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load | cmd.mul_start),
    .a_in  (res_r),
    .b_in  ({1'b0, base_r}),
    .m_in  (m_eff),
    .prod  (u1_p),
    .done  (u1_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= MOD_WIDTH'(1);
      e_r   <= e_wide[EXP_WIDTH-1:0];
    end else if (cmd.take_base) begin
      base_r <= u0_p;
    end else if (cmd.mul_take) begin
      base_r <= u0_p;
      if (e_r[0]) begin
        res_r <= u1_p;
      end
      e_r <= e_r >> 1;
    end
  end

  // Both units start together and run the same number of steps.
  assign sts.exp_zero  = (e_r == '0);
  assign sts.unit_done = u0_done & u1_done;
  assign out_power_result = res_r;

endmodule

`default_nettype wire

[sv/mexp_ctrl.sv]
// Controller state machine sequencing reduction and square-and-multiply.
// Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_strobe,
  output mexp_pkg::cmd_t cmd,
  input  mexp_pkg::sts_t sts
);
  import mexp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_MUL    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts.unit_done) begin
          cmd.take_base = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.exp_zero) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.mul_start = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts.unit_done) begin
          cmd.mul_take = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

endmodule

`default_nettype wire

[sv/modular_exponentiation.sv]
// Top level of the modular exponentiation block.
// Depends on mexp_pkg, mexp_ctrl, mexp_datapath and the assertion macros header.
`default_nettype none

`include "modular_exponentiation_macros.svh"

// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// A word is taken at a rising edge with start high and busy low; in_mode
// high replaces the exponent with modulus - 2, which gives the inverse of
// the base only when the modulus is prime. Only the low EXP_WIDTH bits of
// the exponent are used. The modulus is written through cfg_we/cfg_wdata,
// and the user must write it only while the block is idle; the block
// itself does not enforce this. It resets to 1000000007, and zero acts as
// one. An exponent of zero returns 1 after the base reduction, with no
// square or multiply. The result appears on out_power_result for exactly
// one cycle with out_strobe high; there is no way to hold it off, so the
// receiver must take it in that cycle. busy drops in the same cycle the
// strobe shows, and the next word may start then. The work runs in passes
// of the interleaved modular multipliers, which take 32 steps per product:
// one pass reduces the base, and one pass per exponent bit, up to the
// highest set bit, runs the square and the multiply side by side.
module modular_exponentiation #(
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_mode,
  input  mexp_pkg::word_t in_base_value,
  input  mexp_pkg::word_t in_exponent,
  output logic            out_strobe,
  output mexp_pkg::mod_t  out_power_result,
  input  logic            cfg_we,
  input  mexp_pkg::mod_t  cfg_wdata
);
  import mexp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; all arithmetic sits in the datapath.
  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  mexp_datapath #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_power_result (out_power_result)
  );

  // An accepted word keeps the block busy in the following cycle.
  `MEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // The result strobe only appears once the controller is back in idle.
  `MEXP_ASSERT_SAME(a_strobe_idle, out_strobe, !busy, "result strobe while busy")

  // At most one strobe per word: strobes never come in adjacent cycles.
  `MEXP_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "repeated result strobe")

  // The multipliers only finish while a word is being worked on.
  `MEXP_ASSERT_SAME(a_done_busy, sts.unit_done, busy, "multiplier done while idle")

endmodule

`default_nettype wire
